[hdl/quicksort_lomuto_partition_top_assert.svh]
// Assertion macros for the quicksort block. They expect signals named clk and arst_n in scope.
`ifndef QUICKSORT_LOMUTO_PARTITION_TOP_ASSERT_SVH
`define QUICKSORT_LOMUTO_PARTITION_TOP_ASSERT_SVH

// Checks a property on every rising edge of clk while reset is released.
`define QSLP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Checks that a condition never holds.
`define QSLP_ASSERT_NEVER(label, cond, msg) `QSLP_ASSERT(label, !(cond), msg)

`endif

[hdl/qslp_pkg.sv]
`timescale 1ns / 1ps
package qslp_pkg;
	localparam int DataW = 32;
	localparam int StoreDepthDef = 32;
	localparam int StackDepth = 32;

	typedef logic signed [DataW-1:0] data_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_POP,
		ST_PIVOT,
		ST_CMP,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_FIN_RD,
		ST_FIN_MV,
		ST_FIN_WR,
		ST_PUSH,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_WAIT
	} state_t;
endpackage

[hdl/qslp_ifs.sv]
`timescale 1ns / 1ps
interface qslp_in_if import qslp_pkg::*; ;
	logic  valid;
	logic  ready;
	data_t value;
	logic  last;

	modport source (output valid, value, last, input ready);
	modport sink (input valid, value, last, output ready);
endinterface

interface qslp_out_if import qslp_pkg::*; ;
	logic  valid;
	logic  ready;
	data_t sorted_value;
	logic  final_res;
	logic  overflow;

	modport source (output valid, sorted_value, final_res, overflow, input ready);
	modport sink (input valid, sorted_value, final_res, overflow, output ready);
endinterface

[hdl/quicksort_lomuto_partition_top.sv]
// Collects signed 32-bit values, one per transfer, until a transfer flagged last, then sorts
// them ascending by quicksort (first element as pivot, Lomuto swaps, pending ranges on a
// stack) and sends them out one per transfer, the final one flagged; overflow marks a set
// whose elements beyond STORE_DEPTH were dropped. Loading accepts one element per cycle. The
// values sit in one memory with one write and one registered read port, and that port paces
// the sort: a partition step reads the scanned elements one after another and passes through
// ST_SWAP_A and ST_SWAP_B on each swap; each range also passes through ST_POP, ST_PIVOT and
// the ST_FIN states to pop it, fetch the pivot and place it. Each output element is held until
// the sink takes it. No input is taken from the last transfer of a set until the final result
// of that set has been transferred. No clearing pass is needed after reset.
`timescale 1ns / 1ps
module quicksort_lomuto_partition_top import qslp_pkg::*; #(
	parameter int STORE_DEPTH = StoreDepthDef
) (
	input  logic       clk,
	input  logic       arst_n,
	qslp_in_if.sink    item,
	qslp_out_if.source result
);
	localparam int IW = $clog2(STORE_DEPTH + 1);
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int SPW = $clog2(StackDepth + 1);
	localparam int SIW = $clog2(StackDepth);
	localparam logic [IW-1:0] Depth = IW'(STORE_DEPTH);

	state_t state_q, state_d;

	data_t mem [STORE_DEPTH];
	data_t rdata_q;
	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	data_t mem_wdata;

	logic [IW-1:0] stk_lo [StackDepth];
	logic [IW-1:0] stk_hi [StackDepth];
	logic [SPW-1:0] sp_q;
	logic [SIW-1:0] top_idx;
	logic push_en, push_ok;
	logic [IW-1:0] push_lo, push_hi;

	logic [IW-1:0] count_q, lo_q, hi_q, i_q, j_q, k_q;
	logic dropped_q;
	data_t pivot_q, aj_q, tmp_q;

	logic out_valid_q, final_q, ovf_q;
	data_t sorted_q;

	logic in_xfer, out_xfer, room, less, j_more, big_left;
	logic [IW-1:0] n_next, i_inc, j_inc, k_inc, left_sz, right_sz;
	logic [IW-1:0] first_lo, first_hi, second_lo, second_hi;

	assign item.ready = (state_q == ST_LOAD);
	assign result.valid = out_valid_q;
	assign result.sorted_value = sorted_q;
	assign result.final_res = final_q;
	assign result.overflow = ovf_q;

	assign in_xfer = item.valid && item.ready;
	assign out_xfer = result.valid && result.ready;
	assign room = count_q < Depth;
	assign n_next = room ? IW'(count_q + 1'b1) : count_q;
	assign i_inc = IW'(i_q + 1'b1);
	assign j_inc = IW'(j_q + 1'b1);
	assign k_inc = IW'(k_q + 1'b1);
	assign j_more = j_inc < hi_q;
	assign less = rdata_q < pivot_q;
	assign top_idx = SIW'(sp_q - 1'b1);

	assign left_sz = IW'(i_q - lo_q);
	assign right_sz = IW'(hi_q - i_inc);
	assign big_left = left_sz > right_sz;
	assign first_lo = big_left ? lo_q : i_inc;
	assign first_hi = big_left ? i_q : hi_q;
	assign second_lo = big_left ? i_inc : lo_q;
	assign second_hi = big_left ? hi_q : i_q;

	assign push_ok = push_en && (IW'(push_hi - push_lo) >= IW'(2))
		&& (sp_q < SPW'(StackDepth));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = item.value;
		mem_raddr = '0;
		push_en = 1'b0;
		push_lo = '0;
		push_hi = '0;
		case (state_q)
			ST_LOAD: begin
				if (in_xfer) begin
					mem_we = room;
					mem_waddr = AW'(count_q);
					if (item.last) begin
						push_en = 1'b1;
						push_hi = n_next;
						state_d = ST_POP;
					end
				end
			end
			ST_POP: begin
				if (sp_q == '0) begin
					state_d = ST_EMIT_RD;
				end else begin
					mem_raddr = AW'(stk_lo[top_idx]);
					state_d = ST_PIVOT;
				end
			end
			ST_PIVOT: begin
				mem_raddr = AW'(lo_q + 1'b1);
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (less) begin
					mem_raddr = AW'(i_inc);
					state_d = ST_SWAP_A;
				end else if (j_more) begin
					mem_raddr = AW'(j_inc);
				end else begin
					state_d = ST_FIN_RD;
				end
			end
			ST_SWAP_A: begin
				mem_we = 1'b1;
				mem_waddr = AW'(i_q);
				mem_wdata = aj_q;
				state_d = ST_SWAP_B;
			end
			ST_SWAP_B: begin
				mem_we = 1'b1;
				mem_waddr = AW'(j_q);
				mem_wdata = tmp_q;
				if (j_more) begin
					mem_raddr = AW'(j_inc);
					state_d = ST_CMP;
				end else begin
					state_d = ST_FIN_RD;
				end
			end
			ST_FIN_RD: begin
				mem_raddr = AW'(i_q);
				state_d = ST_FIN_MV;
			end
			ST_FIN_MV: begin
				mem_we = 1'b1;
				mem_waddr = AW'(lo_q);
				mem_wdata = rdata_q;
				state_d = ST_FIN_WR;
			end
			ST_FIN_WR: begin
				mem_we = 1'b1;
				mem_waddr = AW'(i_q);
				mem_wdata = pivot_q;
				push_en = 1'b1;
				push_lo = first_lo;
				push_hi = first_hi;
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				push_en = 1'b1;
				push_lo = second_lo;
				push_hi = second_hi;
				state_d = ST_POP;
			end
			ST_EMIT_RD: begin
				mem_raddr = AW'(k_q);
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				state_d = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				if (out_xfer) begin
					state_d = final_q ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			stk_lo[sp_q[SIW-1:0]] <= push_lo;
			stk_hi[sp_q[SIW-1:0]] <= push_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dropped_q <= 1'b0;
			sp_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				if (room) begin
					count_q <= n_next;
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (push_ok) begin
				sp_q <= SPW'(sp_q + 1'b1);
			end else if (state_q == ST_POP && sp_q != '0) begin
				sp_q <= SPW'(sp_q - 1'b1);
			end
			if (state_q == ST_EMIT_LD) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
				if (final_q) begin
					count_q <= '0;
					dropped_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_POP: begin
				lo_q <= stk_lo[top_idx];
				hi_q <= stk_hi[top_idx];
				k_q <= '0;
			end
			ST_PIVOT: begin
				pivot_q <= rdata_q;
				i_q <= lo_q;
				j_q <= IW'(lo_q + 1'b1);
			end
			ST_CMP: begin
				aj_q <= rdata_q;
				if (less) begin
					i_q <= i_inc;
				end else begin
					j_q <= j_inc;
				end
			end
			ST_SWAP_A: begin
				tmp_q <= rdata_q;
			end
			ST_SWAP_B: begin
				j_q <= j_inc;
			end
			ST_EMIT_LD: begin
				sorted_q <= rdata_q;
				final_q <= (k_inc == count_q);
				ovf_q <= dropped_q;
			end
			ST_EMIT_WAIT: begin
				if (out_xfer) begin
					k_q <= k_inc;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

[hdl/qslp_checker.sv]
`timescale 1ns / 1ps
`include "quicksort_lomuto_partition_top_assert.svh"
module qslp_checker import qslp_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  in_last,
	input logic  out_valid,
	input logic  out_ready,
	input data_t out_value,
	input logic  out_final,
	input logic  out_overflow
);
	`QSLP_ASSERT_NEVER(a_no_load_while_out, in_ready && out_valid, "input taken while a result is pending")
	`QSLP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_final) && $stable(out_overflow), "stalled result changed")
	`QSLP_ASSERT(a_final_returns, out_valid && out_ready && out_final |=> in_ready, "block not ready for a new set after the final result")
	`QSLP_ASSERT(a_load_continues, in_valid && in_ready && !in_last |=> in_ready, "loading stopped before the last element")
	`QSLP_ASSERT(a_last_starts_sort, in_valid && in_ready && in_last |=> !in_ready, "input still taken after the last element")
endmodule

bind quicksort_lomuto_partition_top qslp_checker u_qslp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.in_last      (item.last),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_value    (result.sorted_value),
	.out_final    (result.final_res),
	.out_overflow (result.overflow)
);
